>>> rtl/cen5_pkg.sv
// Shared types and constants for the 5x5 census transform stream core.
// Used by the line store, the top level, the checker and the testbench top; depends on nothing else.
`timescale 1ns / 1ps

package cen5_pkg;

    // Default frame limits, handed to the top-level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int CODE_W = 23;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;

    // Line store geometry: four rows kept, one byte lane per row slot
    localparam int LANES  = 4;
    localparam int LANE_W = 2;

    // Window geometry
    localparam int WIN = 5;

    // Configuration registers
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;

    // Smallest frame side accepted after clamping
    localparam int MIN_SIDE = 5;

    typedef logic signed [PIX_W-1:0] pixel_t;

    // Control for one line store access
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [LANE_W-1:0] wr_lane;
    } ls_ctrl_t;

endpackage

>>> rtl/cen5_line_store.sv
// Line store: four rows of pixels, one byte lane per row slot, packed per column.
// Depends on cen5_pkg for pixel width, lane count and the control struct.
`timescale 1ns / 1ps

module cen5_line_store
    import cen5_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
)
(
    input  logic                      clk,
    input  ls_ctrl_t                  ctrl,
    input  logic [AW-1:0]             addr,
    input  pixel_t                    wr_data,
    output logic [LANES*PIX_W-1:0]    rd_data
);

    logic [LANES*PIX_W-1:0] mem [DEPTH];
    logic [LANES*PIX_W-1:0] rd_data_reg;

    // Read old word and write one lane at the same column in the same cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
        if (ctrl.wr_en)
        begin
            mem[addr][ctrl.wr_lane*PIX_W +: PIX_W] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/census_transform_5x5_stream_core.sv
// Top level of the streaming 5x5 census transform: counters, pipeline, window, code.
// Depends on cen5_pkg and cen5_line_store.
//
//  Channel   Signals                            Beat contents (low bit first)
//  ------    -------------------------------    ------------------------------------------
//  input     s_tvalid s_tready s_tdata[7:0]     pixel (signed)
//  output    m_tvalid m_tready m_tdata m_tlast  census_code, center_column, center_row;
//                                               tlast = last code of the frame
//  config    cfg_we cfg_index cfg_wdata         0: image_width, 1: image_height
//
// One pixel is taken per clock while s_tready is high. After its pixel beat, a code passes
// through the line store read, the window shift, then the compare into the output register.
// Reset clears the counters and pipeline valids and loads 640x480; the line store
// needs no clearing pass. A stalled output fills the two inner stages before
// s_tready drops, and border centers leave the pipeline without using the output.
`timescale 1ns / 1ps

module census_transform_5x5_stream_core
    import cen5_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,    // [22:0] census_code, [33:23] center_column,
                                              // [45:34] center_row, [47:46] zero
    output logic                  m_tlast,    // frame_last

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WEXT = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
    localparam int HEXT = (RW + 1 > HEIGHT_REG_W) ? RW + 1 : HEIGHT_REG_W;
    localparam int CEXT = (CW > COL_W) ? CW : COL_W;
    localparam int REXT = (RW > ROW_W) ? RW : ROW_W;

    // Configuration registers
    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the frame size to the supported range
    logic [WEXT-1:0] width_x;
    logic [WEXT-1:0] width_eff;
    logic [HEXT-1:0] height_x;
    logic [HEXT-1:0] height_eff;

    always_comb
    begin
        width_x  = WEXT'(image_width_reg);
        height_x = HEXT'(image_height_reg);
        if (width_x < WEXT'(MIN_SIDE))
            width_eff = WEXT'(MIN_SIDE);
        else if (width_x > WEXT'(MAX_WIDTH))
            width_eff = WEXT'(MAX_WIDTH);
        else
            width_eff = width_x;
        if (height_x < HEXT'(MIN_SIDE))
            height_eff = HEXT'(MIN_SIDE);
        else if (height_x > HEXT'(MAX_HEIGHT))
            height_eff = HEXT'(MAX_HEIGHT);
        else
            height_eff = height_x;
    end

    // Pipeline handshake
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s2_prod_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s2_free;
    logic s1_free;
    logic accept;

    assign out_ready = !out_valid_reg || m_tready;
    assign s2_free   = !s2_valid_reg || !s2_prod_reg || out_ready;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign s_tready  = s1_free;
    assign accept    = s_tvalid && s1_free;

    // Position counters
    logic [CW-1:0] col_cnt_reg;
    logic [CW-1:0] col_cnt_next;
    logic [RW-1:0] row_cnt_reg;
    logic [RW-1:0] row_cnt_next;
    logic          row_end;
    logic          frame_end;
    logic          produce;
    logic [CEXT-1:0] col_diff;
    logic [REXT-1:0] row_diff;

    always_comb
    begin
        row_end   = WEXT'(col_cnt_reg) >= (width_eff - WEXT'(1));
        frame_end = row_end && (HEXT'(row_cnt_reg) >= (height_eff - HEXT'(1)));
        produce   = (row_cnt_reg >= RW'(4)) && (col_cnt_reg >= CW'(4));
        col_diff  = CEXT'(col_cnt_reg) - CEXT'(2);
        row_diff  = REXT'(row_cnt_reg) - REXT'(2);

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_cnt_next = '0;
                row_cnt_next = frame_end ? '0 : row_cnt_reg + RW'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Line store: read the column of the previous four rows, write this pixel
    ls_ctrl_t               ls_ctrl;
    logic [LANES*PIX_W-1:0] ls_rd_data;

    always_comb
    begin
        ls_ctrl.rd_en   = s1_free;
        ls_ctrl.wr_en   = accept;
        ls_ctrl.wr_lane = row_cnt_reg[LANE_W-1:0];
    end

    cen5_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .ctrl    (ls_ctrl),
        .addr    (col_cnt_reg),
        .wr_data (pixel_t'(s_tdata)),
        .rd_data (ls_rd_data)
    );

    // Stage 1: beat metadata beside the line store read
    pixel_t            s1_px_reg;
    logic [LANE_W-1:0] s1_lane_reg;
    logic              s1_prod_reg;
    logic              s1_last_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= pixel_t'(s_tdata);
            s1_lane_reg <= row_cnt_reg[LANE_W-1:0];
            s1_prod_reg <= produce;
            s1_last_reg <= frame_end;
            s1_col_reg  <= col_diff[COL_W-1:0];
            s1_row_reg  <= row_diff[ROW_W-1:0];
        end
    end

    // Rotate the stored word so that entry 0 is the oldest row
    pixel_t            new_col [WIN];
    logic [LANE_W-1:0] slot    [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            slot[i]    = s1_lane_reg + LANE_W'(i);
            new_col[i] = pixel_t'(ls_rd_data[slot[i]*PIX_W +: PIX_W]);
        end
        new_col[WIN-1] = s1_px_reg;
    end

    // Stage 2: shift the window by one column
    pixel_t           win_reg [WIN][WIN];
    logic             s2_last_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic             s2_move;

    assign s2_move = s1_valid_reg && s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_prod_reg  <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_prod_reg  <= s1_valid_reg && s1_prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][WIN-1] <= new_col[i];
            end
            s2_last_reg <= s1_last_reg;
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
        end
    end

    // Census code: set a bit where the center is greater than the neighbor
    logic [CODE_W-1:0] code;

    always_comb
    begin
        code = '0;
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                if (i * WIN + j >= 2)
                begin
                    code[24 - (i * WIN + j)] = win_reg[2][2] > win_reg[i][j];
                end
            end
        end
    end

    // Output register
    logic [CODE_W-1:0] out_code_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_last_reg;
    logic              out_load;

    assign out_load = s2_valid_reg && s2_prod_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= s2_valid_reg && s2_prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_code_reg <= code;
            out_col_reg  <= s2_col_reg;
            out_row_reg  <= s2_row_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_row_reg, out_col_reg, out_code_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> tb/census_5x5_checker.sv
// Checker for the 5x5 census stream core: follows the pixel and config beats,
// keeps its own copy of the line rows, window and counters, and compares codes.
// Depends on cen5_pkg.
`timescale 1ns / 1ps

module census_5x5_checker
    import cen5_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [47:0]           m_tdata,    // [22:0] census_code, [33:23] center_column,
                                              // [45:34] center_row, [47:46] zero
    input  logic                  m_tlast,    // frame_last

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    output int                    mismatches,
    output int                    pending_codes
);

    localparam int MAX_REPORTS = 40;
    localparam int PAD_LSB     = CODE_W + COL_W + ROW_W;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              last;
    } census_beat_t;

    census_beat_t            owed_codes [$];
    pixel_t                  line_rows [0:LANES*MAX_WIDTH-1];
    pixel_t                  nbhd [0:WIN-1][0:WIN-1];
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    int                      col_pos;
    int                      row_pos;
    census_beat_t            oldest;

    function automatic int clamp_side(input int side, input int hi);
        if (side < MIN_SIDE)
            return MIN_SIDE;
        if (side > hi)
            return hi;
        return side;
    endfunction

    // Count a field mismatch, report the first few
    task automatic note_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // Shift one pixel into the window and owe a code for interior centers
    task automatic predict_census(input pixel_t px);
        int           w;
        int           h;
        int           col;
        int           i;
        int           j;
        int           tap;
        pixel_t       fresh [0:WIN-1];
        pixel_t       center;
        logic         row_end;
        logic         frame_end;
        census_beat_t beat;

        w   = clamp_side(int'(width_reg), MAX_WIDTH);
        h   = clamp_side(int'(height_reg), MAX_HEIGHT);
        col = col_pos % MAX_WIDTH;

        // gather rows r-4 .. r-1 from the line rows, then the new pixel
        for (i = 0; i < LANES; i++)
            fresh[i] = line_rows[((row_pos + i) & 3) * MAX_WIDTH + col];
        fresh[WIN-1] = px;

        for (i = 0; i < WIN; i++)
        begin
            for (j = 0; j < WIN - 1; j++)
                nbhd[i][j] = nbhd[i][j+1];
            nbhd[i][WIN-1] = fresh[i];
        end
        line_rows[(row_pos & 3) * MAX_WIDTH + col] = px;

        row_end   = (col_pos >= w - 1);
        frame_end = row_end && (row_pos >= h - 1);

        if (row_pos >= 4 && col_pos >= 4)
        begin
            center    = nbhd[2][2];
            beat.code = '0;
            // the two leftmost taps of the top row are not part of the code
            for (i = 0; i < WIN; i++)
            begin
                for (j = 0; j < WIN; j++)
                begin
                    tap = i * WIN + j;
                    if (tap >= 2 && center > nbhd[i][j])
                        beat.code[CODE_W + 1 - tap] = 1'b1;
                end
            end
            beat.column = COL_W'(col_pos - 2);
            beat.row    = ROW_W'(row_pos - 2);
            beat.last   = frame_end;
            owed_codes.push_back(beat);
        end

        // advance the raster position, wrap at row and frame end
        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
            owed_codes.delete();
            pending_codes <= 0;
        end
        else
        begin
            // retire an output beat against the oldest owed code
            if (m_tvalid && m_tready)
            begin
                if (owed_codes.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t ns: unexpected code, expected none, got tdata %h tlast %b",
                                 $time, m_tdata, m_tlast);
                end
                else
                begin
                    oldest = owed_codes.pop_front();
                    note_field("census_code", 32'(oldest.code), 32'(m_tdata[CODE_W-1:0]));
                    note_field("center_column", 32'(oldest.column),
                               32'(m_tdata[CODE_W +: COL_W]));
                    note_field("center_row", 32'(oldest.row),
                               32'(m_tdata[CODE_W+COL_W +: ROW_W]));
                    note_field("tdata pad", 32'(0), 32'(m_tdata[47:PAD_LSB]));
                    note_field("frame_last", 32'(oldest.last), 32'(m_tlast));
                end
            end

            // track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_wdata[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_wdata[HEIGHT_REG_W-1:0];
                    default:          ;
                endcase
            end

            if (s_tvalid && s_tready)
                predict_census(pixel_t'(s_tdata));

            pending_codes <= owed_codes.size();
        end
    end

endmodule

>>> tb/census_transform_5x5_stream_core_tb.sv
// Testbench top for the 5x5 census stream core: clock, reset, pixel and config
// stimulus, output backpressure and the verdict. Depends on cen5_pkg, the core
// and census_5x5_checker.
`timescale 1ns / 1ps

module census_transform_5x5_stream_core_tb;
    import cen5_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int pending_codes;
    int cycle_count = 0;

    // stimulus planning: idle shaping and the raster position of the next pixel
    bit idle_on = 1'b1;
    bit long_gaps = 1'b0;
    int eff_w = 640;
    int eff_h = 480;
    int pos_col = 0;
    int pos_row = 0;

    // directed 5x6 frame: extremes, ties with the center, centers at -128 and 127
    int opening_frame [0:29] = '{
           9,   -9,  127, -128,    0,
          -1,    1, -128,  127,  126,
        -127,    0, -128,   64,  -64,
           5, -128,  127,  127,   -2,
           0,  127, -128,    3,   -3,
         100, -100,  126,  127,    0
    };

    census_transform_5x5_stream_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    census_5x5_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending_codes (pending_codes)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mostly no gap, some short ones, a few long ones when allowed
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92 || !long_gaps)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_pixel(input int mode);
        case (mode)
            0: return $urandom_range(0, 255) - 128;
            1: return $urandom_range(0, 2) - 1;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return -128;
                    1: return 127;
                    2: return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // Offer one pixel beat and hold it until accepted
    task automatic send_pixel(input int px);
        int gap;
        gap = idle_on ? idle_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px[PIX_W-1:0];
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // advance the raster position with the sizes in force
        if (pos_col >= eff_w - 1)
        begin
            pos_col = 0;
            pos_row = (pos_row >= eff_h - 1) ? 0 : pos_row + 1;
        end
        else
        begin
            pos_col = pos_col + 1;
        end
    endtask

    task automatic send_run(input int count, input int mode);
        int k;
        for (k = 0; k < count; k++)
            send_pixel(pick_pixel(mode));
    endtask

    // Drain the core, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        int side;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_codes != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
        begin
            side  = value[WIDTH_REG_W-1:0];
            eff_w = side < MIN_SIDE ? MIN_SIDE : (side > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : side);
        end
        else
        begin
            side  = value[HEIGHT_REG_W-1:0];
            eff_h = side < MIN_SIDE ? MIN_SIDE : (side > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : side);
        end
    endtask

    // Output backpressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on)
                    stall_left = idle_gap();
            end
        end
    end

    // Timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int sent;
        int n;
        int rows_left;
        int row_left;
        int frame_left;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed frame: width below the floor clamps to 5, six rows give two codes
        long_gaps = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 6);
        for (n = 0; n < 30; n++)
            send_pixel(opening_frame[n]);

        // wide frame: width above the ceiling clamps to the line store size, so
        // row 0 runs past column 4; then shrink the width to close row 0 and
        // finish four more rows of five
        long_gaps = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 4095);
        write_reg(REG_IMAGE_HEIGHT, 5);
        send_run(20, 0);
        write_reg(REG_IMAGE_WIDTH, 5);
        send_run(1 + 4 * 5, 0);

        // tall frame: height with the top bit set clamps to the maximum, so row 4
        // does not end the frame; cut the height to nine inside the frame
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 8191);
        send_run(5 * 8, 0);
        write_reg(REG_IMAGE_HEIGHT, 9);
        send_run(5, 0);

        // random frames of small sizes, some resized mid-frame
        long_gaps = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (pos_col == 0 && pos_row == 0 && $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    write_reg(REG_IMAGE_WIDTH, $urandom_range(0, 4));
                    2:       write_reg(REG_IMAGE_WIDTH, 13'h1000 | $urandom_range(5, 12));
                    default: write_reg(REG_IMAGE_WIDTH, $urandom_range(5, 14));
                endcase
                case ($urandom_range(0, 9))
                    0, 1:    write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 4));
                    2:       write_reg(REG_IMAGE_HEIGHT, 13'h1000 | $urandom_range(5, 10));
                    default: write_reg(REG_IMAGE_HEIGHT, $urandom_range(5, 12));
                endcase
            end
            else if ((pos_col != 0 || pos_row != 0) && $urandom_range(0, 11) == 0)
            begin
                // only shrink the width inside a frame, the height may go anywhere
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 12));
                else
                    write_reg(REG_IMAGE_WIDTH, $urandom_range(0, eff_w));
            end

            idle_on = ($urandom_range(0, 9) < 7);
            rows_left  = (pos_row >= eff_h - 1) ? 0 : eff_h - 1 - pos_row;
            row_left   = (pos_col >= eff_w - 1) ? 1 : eff_w - pos_col;
            frame_left = rows_left * eff_w + row_left;
            n = $urandom_range(1, 40);
            if (n > frame_left)
                n = frame_left;
            send_run(n, $urandom_range(0, 2));
            sent += n;
        end

        // drain and give the verdict
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_codes != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cen5_pkg.sv
rtl/cen5_line_store.sv
rtl/census_transform_5x5_stream_core.sv
tb/census_5x5_checker.sv
tb/census_transform_5x5_stream_core_tb.sv
